// ===== sv/cpblit_pkg.sv =====
// Shared types and constants of the clipped planar RGB332 blitter.
package cpblit_pkg;

  // Width of every configuration register
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned PLANE_W = 2;
  // Bits of the linear byte address kept before the divide by four
  localparam int unsigned LIN_W   = OFS_W + PLANE_W;

  // Register reset values
  localparam logic [CFG_W-1:0] DEST_X_RST        = 11'd0;
  localparam logic [CFG_W-1:0] DEST_Y_RST        = 11'd0;
  localparam logic [CFG_W-1:0] WIN_WIDTH_RST     = 11'd320;
  localparam logic [CFG_W-1:0] WIN_HEIGHT_RST    = 11'd240;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 11'd240;

  // Register indexes on the write port
  typedef enum logic [IDX_W-1:0] {
    CFG_DEST_X        = 3'd0,
    CFG_DEST_Y        = 3'd1,
    CFG_WIN_WIDTH     = 3'd2,
    CFG_WIN_HEIGHT    = 3'd3,
    CFG_SCREEN_WIDTH  = 3'd4,
    CFG_SCREEN_HEIGHT = 3'd5
  } cfg_idx_e;

  // Register file contents; dest_x and dest_y hold two's complement values
  typedef struct packed {
    logic [CFG_W-1:0] dest_x;
    logic [CFG_W-1:0] dest_y;
    logic [CFG_W-1:0] win_width;
    logic [CFG_W-1:0] win_height;
    logic [CFG_W-1:0] screen_width;
    logic [CFG_W-1:0] screen_height;
  } cfg_t;

endpackage

// ===== sv/cpblit_if.sv =====
// Valid/ready channels for source pixels and framebuffer write requests.
interface cpblit_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface cpblit_wr_if;
  logic        valid;
  logic        ready;
  logic [1:0]  plane;
  logic [15:0] frame_offset;
  logic [7:0]  color_index;

  modport source (output valid, output plane, output frame_offset, output color_index,
                  input ready);
  modport sink   (input valid, input plane, input frame_offset, input color_index,
                  output ready);
endinterface

// ===== sv/clipped_planar_rgb332_blit.sv =====
// Top level of the clipped planar RGB332 blitter.
//
// Source pixels arrive on pix_i in raster order of the window, one request
// per pixel. Each pixel is placed at (dest_x + column, dest_y + row); pixels
// off the screen are dropped, visible ones leave on wr_o as a write request
// carrying the plane (x mod 4), the byte offset within the plane with rows
// flipped and the RGB332 color byte.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Unknown indexes are ignored. An accepted pixel passes the input
// register (counters, position, color), then the request register (clip
// compare and the row times width multiply) on its way to its write request.
// Throughput is one pixel per cycle while wr_o takes requests.
// When wr_o stalls, the request register holds, the input register fills,
// and pix_i.ready drops until the request is taken.
// Reset clears the raster counters and both valid flags and loads the
// register reset values (320x240 window and screen at the origin).
module clipped_planar_rgb332_blit
  import cpblit_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  cpblit_pix_if.sink       pix_i,
  cpblit_wr_if.source      wr_o
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned XW = ((CW > CFG_W) ? CW : CFG_W) + 2;

  cfg_t               cfg;
  logic               s1_valid;
  logic [XW-1:0]      s1_x;
  logic [XW-1:0]      s1_y;
  logic [COLOR_W-1:0] s1_color;
  logic               s1_take;

  cpblit_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cpblit_walk #(
    .MAX_DIM (MAX_DIM),
    .CW      (CW),
    .XW      (XW)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_i      (pix_i),
    .s1_valid_o (s1_valid),
    .s1_x_o     (s1_x),
    .s1_y_o     (s1_y),
    .s1_color_o (s1_color),
    .s1_take_i  (s1_take)
  );

  cpblit_pix #(
    .XW (XW)
  ) u_pix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_x_i     (s1_x),
    .s1_y_i     (s1_y),
    .s1_color_i (s1_color),
    .s1_take_o  (s1_take),
    .wr_o       (wr_o)
  );

  // An empty request register never back-pressures the pixel input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_o.valid |-> pix_i.ready)
    else $error("pixel input stalled with empty request register");

  // A pixel in the input register that is not taken stays there
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s1_take) |=> s1_valid)
    else $error("pixel lost from input register");

  // An accepted pixel lands in the input register
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> s1_valid)
    else $error("accepted pixel not registered");

endmodule

// ===== sv/cpblit_cfg.sv =====
// Configuration register file of the blitter.
module cpblit_cfg
  import cpblit_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write request; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEST_X:        cfg_d.dest_x        = cfg_wdata_i;
        CFG_DEST_Y:        cfg_d.dest_y        = cfg_wdata_i;
        CFG_WIN_WIDTH:     cfg_d.win_width     = cfg_wdata_i;
        CFG_WIN_HEIGHT:    cfg_d.win_height    = cfg_wdata_i;
        CFG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_wdata_i;
        CFG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x        <= DEST_X_RST;
      cfg_q.dest_y        <= DEST_Y_RST;
      cfg_q.win_width     <= WIN_WIDTH_RST;
      cfg_q.win_height    <= WIN_HEIGHT_RST;
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/cpblit_walk.sv =====
// Input stage: window raster counters, screen position and color packing.
module cpblit_walk
  import cpblit_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024,
  parameter int unsigned CW      = $clog2(MAX_DIM),
  parameter int unsigned XW      = ((CW > CFG_W) ? CW : CFG_W) + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  cpblit_pix_if.sink           pix_i,
  output logic                 s1_valid_o,
  output logic [XW-1:0]        s1_x_o,
  output logic [XW-1:0]        s1_y_o,
  output logic [COLOR_W-1:0]   s1_color_o,
  input  logic                 s1_take_i
);

  // Width that holds the counter plus one and any register value
  localparam int unsigned DW = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;

  logic [CW-1:0]      col_q, col_d;
  logic [CW-1:0]      row_q, row_d;
  logic               valid_q, valid_d;
  logic [XW-1:0]      x_q, x_d;
  logic [XW-1:0]      y_q, y_d;
  logic [COLOR_W-1:0] color_q, color_d;

  logic          accept;
  logic [DW-1:0] win_w, win_h, eff_w, eff_h;
  logic [DW-1:0] col_inc, row_inc;

  assign pix_i.ready = !valid_q || s1_take_i;
  assign accept      = pix_i.valid && pix_i.ready;

  // Clamp the window size to one..MAX_DIM
  always_comb begin
    win_w = DW'(cfg_i.win_width);
    win_h = DW'(cfg_i.win_height);
    if (win_w == '0) begin
      eff_w = DW'(1);
    end else if (win_w > DW'(MAX_DIM)) begin
      eff_w = DW'(MAX_DIM);
    end else begin
      eff_w = win_w;
    end
    if (win_h == '0) begin
      eff_h = DW'(1);
    end else if (win_h > DW'(MAX_DIM)) begin
      eff_h = DW'(MAX_DIM);
    end else begin
      eff_h = win_h;
    end
  end

  // Advance the raster counters on each accepted request
  always_comb begin
    col_inc = DW'(col_q) + DW'(1);
    row_inc = DW'(row_q) + DW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= eff_w) begin
        col_d = '0;
        row_d = (row_inc >= eff_h) ? '0 : row_inc[CW-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  // Place the pixel on screen and pack RGB332
  always_comb begin
    x_d = XW'($signed({{(XW-CFG_W){cfg_i.dest_x[CFG_W-1]}}, cfg_i.dest_x})
              + $signed({{(XW-CW){1'b0}}, col_q}));
    y_d = XW'($signed({{(XW-CFG_W){cfg_i.dest_y[CFG_W-1]}}, cfg_i.dest_y})
              + $signed({{(XW-CW){1'b0}}, row_q}));
    color_d = {pix_i.red[7:5], pix_i.green[7:5], pix_i.blue[7:6]};
    valid_d = accept ? 1'b1 : (s1_take_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  // Hold the payload until the next accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= x_d;
      y_q     <= y_d;
      color_q <= color_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_x_o     = x_q;
  assign s1_y_o     = y_q;
  assign s1_color_o = color_q;

endmodule

// ===== sv/cpblit_pix.sv =====
// Output stage: screen clipping, planar address and write request register.
module cpblit_pix
  import cpblit_pkg::*;
#(
  parameter int unsigned XW = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               s1_valid_i,
  input  logic [XW-1:0]      s1_x_i,
  input  logic [XW-1:0]      s1_y_i,
  input  logic [COLOR_W-1:0] s1_color_i,
  output logic               s1_take_o,
  cpblit_wr_if.source        wr_o
);

  logic               valid_q, valid_d;
  logic [PLANE_W-1:0] plane_q;
  logic [OFS_W-1:0]   ofs_q;
  logic [COLOR_W-1:0] color_q;

  logic [XW-2:0]        ux, uy;
  logic                 vis;
  logic [CFG_W-1:0]     flipped;
  logic [2*CFG_W-1:0]   prod;
  logic [LIN_W-1:0]     lin;
  logic                 load;

  // Clip against the screen
  always_comb begin
    ux  = s1_x_i[XW-2:0];
    uy  = s1_y_i[XW-2:0];
    vis = !s1_x_i[XW-1] && !s1_y_i[XW-1]
          && (ux < {{(XW-1-CFG_W){1'b0}}, cfg_i.screen_width})
          && (uy < {{(XW-1-CFG_W){1'b0}}, cfg_i.screen_height});
  end

  // Linear address with the rows flipped; offset is that divided by four
  always_comb begin
    flipped = cfg_i.screen_height - CFG_W'(1) - uy[CFG_W-1:0];
    prod    = flipped * cfg_i.screen_width;
    lin     = LIN_W'(prod) + LIN_W'(ux);
  end

  assign s1_take_o = !valid_q || wr_o.ready;
  assign load      = s1_take_o && s1_valid_i && vis;

  // Invisible pixels are dropped here
  always_comb begin
    valid_d = s1_take_o ? (s1_valid_i && vis) : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plane_q <= ux[PLANE_W-1:0];
      ofs_q   <= lin[LIN_W-1:PLANE_W];
      color_q <= s1_color_i;
    end
  end

  assign wr_o.valid        = valid_q;
  assign wr_o.plane        = plane_q;
  assign wr_o.frame_offset = ofs_q;
  assign wr_o.color_index  = color_q;

endmodule

// ===== tb/tb_clipped_planar_rgb332_blit.sv =====
// Self-checking testbench for the clipped planar RGB332 blitter: predicts each write request.
`timescale 1ns / 1ps

module tb_clipped_planar_rgb332_blit;
  import cpblit_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int MAX_DIM         = 1024;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_ITEMS    = 770;

  // Indexes past the register file; writes to them must change nothing
  localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PLANE_W-1:0] plane;
    logic [OFS_W-1:0]   frame_offset;
    logic [COLOR_W-1:0] color_index;
  } fb_write_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  cpblit_pix_if pix ();
  cpblit_wr_if  wr ();

  clipped_planar_rgb332_blit #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i      (pix),
    .wr_o       (wr)
  );

  // Shadow of the register file and of the raster counters
  cfg_t        shadow_cfg;
  int unsigned raster_col;
  int unsigned raster_row;
  fb_write_t   expected_writes[$];
  int          mismatch_count;

  // Traffic shaping knobs
  bit pix_gaps_on;
  bit wr_stalls_on;
  bit hold_off_req;
  int stall_left;
  int idle_cycles;

  fb_write_t got_write;
  fb_write_t want_write;

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Zero acts as one, anything past the counter range acts as the range
  function automatic int unsigned window_extent(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Place one pixel on the screen, queue its write request if visible, advance the raster
  task automatic place_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int        x;
    int        y;
    int        flipped;
    int        lin;
    fb_write_t w;
    x = int'($signed(shadow_cfg.dest_x)) + int'(raster_col);
    y = int'($signed(shadow_cfg.dest_y)) + int'(raster_row);
    if (x >= 0 && y >= 0 && x < int'(shadow_cfg.screen_width) &&
        y < int'(shadow_cfg.screen_height)) begin
      flipped = int'(shadow_cfg.screen_height) - 1 - y;
      lin = flipped * int'(shadow_cfg.screen_width) + x;
      w.plane = x[1:0];
      w.frame_offset = lin[17:2];
      w.color_index = {r[7:5], g[7:5], b[7:6]};
      expected_writes.push_back(w);
    end
    if (raster_col + 1 >= window_extent(shadow_cfg.win_width)) begin
      raster_col = 0;
      if (raster_row + 1 >= window_extent(shadow_cfg.win_height)) begin
        raster_row = 0;
      end else begin
        raster_row++;
      end
    end else begin
      raster_col++;
    end
  endtask

  // Write one register; call at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(posedge clk_i);
    case (idx)
      CFG_DEST_X:        shadow_cfg.dest_x = value;
      CFG_DEST_Y:        shadow_cfg.dest_y = value;
      CFG_WIN_WIDTH:     shadow_cfg.win_width = value;
      CFG_WIN_HEIGHT:    shadow_cfg.win_height = value;
      CFG_SCREEN_WIDTH:  shadow_cfg.screen_width = value;
      CFG_SCREEN_HEIGHT: shadow_cfg.screen_height = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_window(input int dx, input int dy, input int ww, input int wh,
                            input int sw, input int sh);
    write_reg(CFG_DEST_X, CFG_W'(dx));
    write_reg(CFG_DEST_Y, CFG_W'(dy));
    write_reg(CFG_WIN_WIDTH, CFG_W'(ww));
    write_reg(CFG_WIN_HEIGHT, CFG_W'(wh));
    write_reg(CFG_SCREEN_WIDTH, CFG_W'(sw));
    write_reg(CFG_SCREEN_HEIGHT, CFG_W'(sh));
  endtask

  // Offer one pixel request and hold it until taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int gap;
    gap = pix_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.red = r;
    pix.green = g;
    pix.blue = b;
    do @(posedge clk_i); while (!pix.ready);
    place_pixel(r, g, b);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stop offering, drain every expected request, then let the pipeline settle
  task automatic wait_idle(input int settle);
    pix.valid = 1'b0;
    while (expected_writes.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic test_reset_values();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    wait_idle(SETTLE_CYCLES);
  endtask

  // Window hanging off the left edge and past the last row of a tiny screen
  task automatic test_clipping();
    set_window(-1, 1, 3, 2, 4, 2);
    send_pixel(8'hE0, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hE0, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hC0);
    send_pixel(8'h1F, 8'h1F, 8'h3F);
    send_pixel(8'hA0, 8'h40, 8'h80);
    send_pixel(8'h5F, 8'hBF, 8'h7F);
    wait_idle(SETTLE_CYCLES);
  endtask

  // Zero window size, then a window shrunk under the running counters
  task automatic test_window_corners();
    set_window(0, 0, 0, 0, 8, 2);
    send_random_pixel();
    send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_WIN_WIDTH, 11'd8);
    write_reg(CFG_WIN_HEIGHT, 11'd2);
    repeat (3) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_WIN_WIDTH, 11'd2);
    repeat (3) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
  endtask

  // Zero screen sizes, odd screen width, offsets that wrap at 16 bits
  task automatic test_screen_corners();
    set_window(0, 0, 4, 2, 0, 2);
    send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    write_reg(CFG_SCREEN_WIDTH, 11'd8);
    write_reg(CFG_SCREEN_HEIGHT, 11'd0);
    send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    set_window(0, 0, 5, 1, 5, 3);
    repeat (4) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    set_window(1020, 0, 4, 1, 1024, 1024);
    repeat (2) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
  endtask

  // Writes past the register file leave the setup alone
  task automatic test_unknown_index();
    set_window(0, 0, 2, 2, 4, 4);
    write_reg(IDX_SPARE_LO, 11'h7FF);
    write_reg(IDX_SPARE_HI, 11'h7FF);
    send_random_pixel();
    wait_idle(SETTLE_CYCLES);
  endtask

  // Oversized window clamps to the counter range instead of wrapping early
  task automatic test_oversized_window();
    set_window(0, 0, 1025, 2047, 8, 4);
    repeat (6) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    set_window(0, 0, 1, 1025, 4, 8);
    repeat (6) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
  endtask

  // Hold off the write side while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    set_window(0, 0, 8, 4, 8, 4);
    pix_gaps_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_random_pixel();
    wait_idle(SETTLE_CYCLES);
    pix_gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int sent;
    int n;
    int dx;
    int dy;
    int ww;
    int wh;
    int sw;
    int sh;
    int roll;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) sw = 1024;
      else if (roll == 1) sw = 0;
      else if (roll == 2) sw = $urandom_range(1, 40) | 1;
      else sw = 4 * $urandom_range(1, 10);
      roll = $urandom_range(0, 19);
      if (roll == 0) sh = 1024;
      else if (roll == 1) sh = 0;
      else sh = $urandom_range(1, 12);
      roll = $urandom_range(0, 19);
      if (roll == 0) ww = 0;
      else if (roll == 1) ww = $urandom_range(1025, 2047);
      else ww = $urandom_range(1, 16);
      wh = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
      roll = $urandom_range(0, 19);
      if (roll == 0) dx = -1024;
      else if (roll == 1) dx = 1023;
      else dx = int'($urandom_range(0, sw + 16)) - 8;
      if (dx > 1023) dx = 1023;
      roll = $urandom_range(0, 19);
      if (roll == 0) dy = -1024;
      else if (roll == 1) dy = 1023;
      else dy = int'($urandom_range(0, sh + 12)) - 6;
      if (dy > 1023) dy = 1023;
      set_window(dx, dy, ww, wh, sw, sh);
      pix_gaps_on = ($urandom_range(0, 3) != 0);
      wr_stalls_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(15, 70);
      repeat (n) begin
        send_random_pixel();
        // Now and then pause until every request is back
        if ($urandom_range(0, 49) == 0) wait_idle(0);
      end
      sent += n;
      wait_idle(SETTLE_CYCLES);
    end
    pix_gaps_on = 1'b1;
    wr_stalls_on = 1'b1;
  endtask

  // Write side ready: random stalls, plus one long hold-off on request
  initial begin
    wr.ready = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        wr.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        wr.ready = 1'b0;
        stall_left--;
      end else begin
        wr.ready = 1'b1;
        if (wr_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Check each write request against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && wr.valid && wr.ready) begin
      got_write.plane = wr.plane;
      got_write.frame_offset = wr.frame_offset;
      got_write.color_index = wr.color_index;
      if (expected_writes.size() == 0) begin
        $error("unexpected write request: plane %0d offset %0d color %0h",
               got_write.plane, got_write.frame_offset, got_write.color_index);
        mismatch_count++;
      end else begin
        want_write = expected_writes.pop_front();
        if (got_write.plane !== want_write.plane) begin
          $error("plane: expected %0d, got %0d", want_write.plane, got_write.plane);
          mismatch_count++;
        end
        if (got_write.frame_offset !== want_write.frame_offset) begin
          $error("frame_offset: expected %0d, got %0d",
                 want_write.frame_offset, got_write.frame_offset);
          mismatch_count++;
        end
        if (got_write.color_index !== want_write.color_index) begin
          $error("color_index: expected %0h, got %0h",
                 want_write.color_index, got_write.color_index);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no request moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix.valid && pix.ready) || (wr.valid && wr.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("clipped_planar_rgb332_blit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    shadow_cfg = '{dest_x: DEST_X_RST, dest_y: DEST_Y_RST,
                   win_width: WIN_WIDTH_RST, win_height: WIN_HEIGHT_RST,
                   screen_width: SCREEN_WIDTH_RST, screen_height: SCREEN_HEIGHT_RST};
    raster_col = 0;
    raster_row = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    pix_gaps_on = 1'b1;
    wr_stalls_on = 1'b1;
    hold_off_req = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_clipping();
    test_window_corners();
    test_screen_corners();
    test_unknown_index();
    test_backpressure();
    test_oversized_window();
    test_random_frames();

    wait_idle(SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("clipped_planar_rgb332_blit test passed");
    end else begin
      $display("clipped_planar_rgb332_blit test failed");
    end
    $finish;
  end

endmodule

// ===== clipped_planar_rgb332_blit.f =====
sv/cpblit_pkg.sv
sv/cpblit_if.sv
sv/cpblit_cfg.sv
sv/cpblit_walk.sv
sv/cpblit_pix.sv
sv/clipped_planar_rgb332_blit.sv
tb/tb_clipped_planar_rgb332_blit.sv
